// File: hw/rtl/calendar_queue_timer_defines.svh
// Assertion macros for the calendar queue timer RTL.
`ifndef CALENDAR_QUEUE_TIMER_DEFINES_SVH
`define CALENDAR_QUEUE_TIMER_DEFINES_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define CQT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("calendar queue timer assertion failed");
// A condition that must hold in the cycle after a trigger.
`define CQT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) \
    else $error("calendar queue timer sequence assertion failed");
`else
`define CQT_ASSERT(lbl, clk, rstn, prop)
`define CQT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/cqt_pkg.sv
`default_nettype none
package cqt_pkg;

  // Default geometry.
  localparam int BUCKETS_DEF = 16;
  localparam int ENTRIES_DEF = 64;

  // Widths fixed by the largest supported geometry and by the item fields.
  localparam int ID_W      = 10;
  localparam int BKT_W     = 10;
  localparam int TW        = 32;
  localparam int DVD_W     = 33;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_SPAN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME  = 2'd1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POLL   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_NONE  = 3'd1,
    ST_FULL  = 3'd2,
    ST_EARLY = 3'd3,
    ST_FREE  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_A,
    S_DIV_P,
    S_SCAN,
    S_EVAL,
    S_MUL,
    S_APPLY,
    S_DONE
  } state_e;

  // Search wave passed from cell to cell along the chain.
  typedef struct packed {
    logic             vld;
    logic [BKT_W-1:0] bkt;
    logic             hit;
    logic [ID_W-1:0]  hd_id;
    logic [TW-1:0]    hd_time;
    logic [TW-1:0]    hd_order;
    logic [TW-1:0]    hd_tag;
    logic             fr_hit;
    logic [ID_W-1:0]  fr_id;
  } wave_t;

  // Slot update broadcast to all cells.
  typedef struct packed {
    logic             we;
    logic             clr;
    logic [ID_W-1:0]  id;
    logic [TW-1:0]    deadline;
    logic [TW-1:0]    tag;
    logic [BKT_W-1:0] bkt;
    logic [TW-1:0]    order;
  } cell_wr_t;

  // Wrap-aware a >= b on 32 bits.
  function automatic logic time_ge(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW-1:0] d;
    d = a - b;
    return !d[TW-1];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cqt_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module cqt_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [cqt_pkg::DVD_W-1:0] dividend_i,
  input  wire logic [cqt_pkg::TW-1:0]    divisor_i,
  output logic                           done_o,
  output logic [cqt_pkg::DVD_W-1:0]      quotient_o
);
  localparam int CNT_W = $clog2(cqt_pkg::DVD_W + 1);

  logic                      busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [cqt_pkg::DVD_W-1:0] rem_q, rem_d, quo_q, quo_d, trial;
  logic [cqt_pkg::TW-1:0]    dvs_q, dvs_d;

  // One shift and trial subtraction per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    trial  = {rem_q[cqt_pkg::DVD_W-2:0], quo_q[cqt_pkg::DVD_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(cqt_pkg::DVD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[cqt_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[cqt_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

// File: hw/rtl/cqt_cell.sv
`default_nettype none
// One pool slot. It folds itself into the passing search wave and hands
// the registered wave on to the next cell.
module cqt_cell #(
  parameter int BUCKETS = cqt_pkg::BUCKETS_DEF,
  parameter int IDX     = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cqt_pkg::wave_t   wave_i,
  output cqt_pkg::wave_t        wave_o,
  input  wire cqt_pkg::cell_wr_t wr_i,
  output logic                  valid_o
);
  localparam int BW = $clog2(BUCKETS);

  logic                   v_q;
  logic [cqt_pkg::TW-1:0] dl_q, tg_q, or_q;
  logic [BW-1:0]          bk_q;
  logic                   vld_q;
  cqt_pkg::wave_t         pay_q, pay_d;
  logic                   mine, better, sel;

  // Compare this slot against the best head seen so far.
  always_comb begin
    mine = v_q && (wave_i.bkt == cqt_pkg::BKT_W'(bk_q));
    if (!wave_i.hit) begin
      better = 1'b1;
    end else if (dl_q != wave_i.hd_time) begin
      better = !cqt_pkg::time_ge(dl_q, wave_i.hd_time);
    end else begin
      better = !cqt_pkg::time_ge(or_q, wave_i.hd_order);
    end
    sel   = wr_i.id == cqt_pkg::ID_W'(IDX);
    pay_d = wave_i;
    if (mine && better) begin
      pay_d.hit      = 1'b1;
      pay_d.hd_id    = cqt_pkg::ID_W'(IDX);
      pay_d.hd_time  = dl_q;
      pay_d.hd_order = or_q;
      pay_d.hd_tag   = tg_q;
    end
    if (!wave_i.fr_hit && !v_q) begin
      pay_d.fr_hit = 1'b1;
      pay_d.fr_id  = cqt_pkg::ID_W'(IDX);
    end
  end

  // Occupancy and wave valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= wave_i.vld;
      if (wr_i.we && sel) begin
        v_q <= 1'b1;
      end else if (wr_i.clr && sel) begin
        v_q <= 1'b0;
      end
    end
  end

  // Slot contents and wave payload.
  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
    if (wr_i.we && sel) begin
      dl_q <= wr_i.deadline;
      tg_q <= wr_i.tag;
      bk_q <= wr_i.bkt[BW-1:0];
      or_q <= wr_i.order;
    end
  end

  always_comb begin
    wave_o     = pay_q;
    wave_o.vld = vld_q;
  end

  assign valid_o = v_q;
endmodule
`default_nettype wire

// File: hw/rtl/calendar_queue_timer.sv
`default_nettype none
`include "calendar_queue_timer_defines.svh"
// Calendar queue of timeouts over a pool of ENTRIES slots in BUCKETS buckets,
// kept in a chain of slot cells that a search wave walks through, one cell a
// cycle. BUCKETS must be a power of two, as bucket numbers wrap by dropping
// the upper bits. One item is processed at a time; the next is taken while a
// result still waits at the output. A remove answers straight from the decode
// step. An add makes one pass of the bit-serial divider for the bucket number
// and one wave through the chain for the lowest free slot. A poll makes one
// divider pass and sends one wave per bucket visited, at most BUCKETS. A poll
// whose time is behind the elapsed time, and an add that is too early, also
// answer straight from the decode step. Slot occupancy resets at once; no
// clearing pass is needed.
module calendar_queue_timer #(
  parameter int BUCKETS = cqt_pkg::BUCKETS_DEF,
  parameter int ENTRIES = cqt_pkg::ENTRIES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [31:0]                   time_value_i,
  input  wire logic [31:0]                   handle_i,
  input  wire logic [5:0]                    entry_id_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [2:0]                         status_o,
  output logic [5:0]                         result_id_o,
  output logic [31:0]                        result_handle_o,
  output logic [31:0]                        result_timeout_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cqt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i
);
  localparam int BW = $clog2(BUCKETS);
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(BUCKETS + 1);
  localparam int TW = cqt_pkg::TW;
  localparam int DW = cqt_pkg::DVD_W;

  cqt_pkg::state_e  state_q, state_d;
  cqt_pkg::op_e     op_q, op_d;
  logic [TW-1:0]    tv_q, tv_d, hd_q, hd_d;
  logic [5:0]       id_q, id_d;
  logic [TW-1:0]    span_q, span_d, elapsed_q, elapsed_d, ictr_q, ictr_d;
  logic [BW-1:0]    cur_q, cur_d, b_q, b_d, hbkt_q, hbkt_d;
  logic [TW-1:0]    n_q, n_d, mul_a_q, mul_a_d, prod_q, prod_d;
  logic [CW-1:0]    k_q, k_d, r_q, r_d, lim_q, lim_d, hk_q, hk_d;
  logic             hit_q, hit_d;
  logic [IW-1:0]    hid_q, hid_d;
  logic [TW-1:0]    htag_q, htag_d, htime_q, htime_d;
  cqt_pkg::status_e res_st_q, res_st_d, out_st_q, out_st_d;
  logic [5:0]       res_id_q, res_id_d, out_id_q, out_id_d;
  logic [TW-1:0]    res_hdl_q, res_hdl_d, res_to_q, res_to_d;
  logic [TW-1:0]    out_hdl_q, out_hdl_d, out_to_q, out_to_d;
  logic             out_vld_q, out_vld_d;

  logic             div_start, div_done;
  logic [DW-1:0]    div_dvd, div_quo;
  logic [TW-1:0]    div_dvs;
  logic [TW-1:0]    span_eff, diff_p;
  logic [TW-1:0]    prod_full;
  logic             rm_ok, in_fire;
  logic [ENTRIES-1:0] vld_vec;
  cqt_pkg::wave_t   chain [ENTRIES+1];
  cqt_pkg::wave_t   launch, chain_end;
  cqt_pkg::cell_wr_t cell_wr;

  assign in_ready_o  = state_q == cqt_pkg::S_IDLE;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign span_eff    = (span_q == '0) ? TW'(1) : span_q;
  assign diff_p      = tv_q - elapsed_q;
  assign prod_full   = mul_a_q * span_eff;
  assign rm_ok       = (32'(id_q) < 32'(ENTRIES)) && vld_vec[IW'(id_q)];
  assign chain_end   = chain[ENTRIES];
  assign chain[0]    = launch;

  cqt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Chain of slot cells.
  for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
    cqt_cell #(
      .BUCKETS (BUCKETS),
      .IDX     (gi)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wave_i  (chain[gi]),
      .wave_o  (chain[gi+1]),
      .wr_i    (cell_wr),
      .valid_o (vld_vec[gi])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cqt_pkg::S_IDLE:   if (in_valid_i) state_d = cqt_pkg::S_DECODE;
      cqt_pkg::S_DECODE: begin
        case (op_q)
          cqt_pkg::OP_ADD: begin
            state_d = cqt_pkg::time_ge(tv_q, elapsed_q) ? cqt_pkg::S_DIV_A
                                                        : cqt_pkg::S_DONE;
          end
          cqt_pkg::OP_POLL: begin
            state_d = diff_p[TW-1] ? cqt_pkg::S_DONE : cqt_pkg::S_DIV_P;
          end
          default: state_d = cqt_pkg::S_DONE;
        endcase
      end
      cqt_pkg::S_DIV_A: if (div_done) state_d = cqt_pkg::S_SCAN;
      cqt_pkg::S_DIV_P: if (div_done) state_d = cqt_pkg::S_SCAN;
      cqt_pkg::S_SCAN: begin
        if (chain_end.vld && (CW'(r_q + 1'b1) == lim_q)) state_d = cqt_pkg::S_EVAL;
      end
      cqt_pkg::S_EVAL: begin
        state_d = (op_q == cqt_pkg::OP_POLL) ? cqt_pkg::S_MUL : cqt_pkg::S_DONE;
      end
      cqt_pkg::S_MUL:   state_d = cqt_pkg::S_APPLY;
      cqt_pkg::S_APPLY: state_d = cqt_pkg::S_DONE;
      cqt_pkg::S_DONE:  if (!out_vld_q || out_ready_i) state_d = cqt_pkg::S_IDLE;
      default:          state_d = cqt_pkg::S_IDLE;
    endcase
  end

  // Datapath and control outputs.
  always_comb begin
    op_d      = op_q;      tv_d     = tv_q;     hd_d     = hd_q;    id_d   = id_q;
    span_d    = span_q;    elapsed_d = elapsed_q; ictr_d = ictr_q;  cur_d  = cur_q;
    b_d       = b_q;       n_d      = n_q;      mul_a_d  = mul_a_q; prod_d = prod_q;
    k_d       = k_q;       r_d      = r_q;      lim_d    = lim_q;   hk_d   = hk_q;
    hit_d     = hit_q;     hid_d    = hid_q;    htag_d   = htag_q;  htime_d = htime_q;
    hbkt_d    = hbkt_q;
    res_st_d  = res_st_q;  res_id_d = res_id_q; res_hdl_d = res_hdl_q; res_to_d = res_to_q;
    out_st_d  = out_st_q;  out_id_d = out_id_q; out_hdl_d = out_hdl_q; out_to_d = out_to_q;
    out_vld_d = out_vld_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    launch    = '0;
    cell_wr   = '0;

    if (out_vld_q && out_ready_i) out_vld_d = 1'b0;

    case (state_q)
      cqt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d = cqt_pkg::op_e'(operation_i);
          tv_d = time_value_i;
          hd_d = handle_i;
          id_d = entry_id_i;
        end
      end
      cqt_pkg::S_DECODE: begin
        res_st_d  = cqt_pkg::ST_NONE;
        res_id_d  = '0;
        res_hdl_d = '0;
        res_to_d  = '0;
        case (op_q)
          cqt_pkg::OP_ADD: begin
            if (!cqt_pkg::time_ge(tv_q, elapsed_q)) begin
              res_st_d = cqt_pkg::ST_EARLY;
            end else begin
              div_start = 1'b1;
              div_dvd   = DW'(diff_p);
              div_dvs   = span_eff;
            end
          end
          cqt_pkg::OP_REMOVE: begin
            if (rm_ok) begin
              cell_wr.clr = 1'b1;
              cell_wr.id  = cqt_pkg::ID_W'(id_q);
              res_st_d    = cqt_pkg::ST_OK;
              res_id_d    = id_q;
            end else begin
              res_st_d = cqt_pkg::ST_FREE;
            end
          end
          cqt_pkg::OP_POLL: begin
            // The step count comes from whichever form of the span fits.
            if (!diff_p[TW-1]) begin
              div_start = 1'b1;
              if (span_eff <= 32'h8000_0000) begin
                div_dvd = DW'(diff_p);
                div_dvs = span_eff;
              end else begin
                div_dvd = DW'(32'h7FFF_FFFF - diff_p);
                div_dvs = '0 - span_eff;
              end
            end
          end
          default: ;
        endcase
      end
      cqt_pkg::S_DIV_A: begin
        // The bucket number wraps by keeping only its low bits.
        if (div_done) begin
          b_d   = div_quo[BW-1:0] + cur_q;
          k_d   = '0;
          r_d   = '0;
          lim_d = CW'(1);
          hit_d = 1'b0;
        end
      end
      cqt_pkg::S_DIV_P: begin
        if (div_done) begin
          n_d   = div_quo[TW-1:0] + 1'b1;
          lim_d = (div_quo[TW-1:0] + 1'b1 < TW'(BUCKETS)) ? CW'(div_quo[TW-1:0] + 1'b1)
                                                          : CW'(BUCKETS);
          b_d   = cur_q;
          k_d   = '0;
          r_d   = '0;
          hit_d = 1'b0;
        end
      end
      cqt_pkg::S_SCAN: begin
        // Launch one wave per bucket, then collect them at the chain end.
        if (k_q < lim_q) begin
          launch.vld = 1'b1;
          launch.bkt = cqt_pkg::BKT_W'(b_q);
          k_d        = k_q + 1'b1;
          if (op_q == cqt_pkg::OP_POLL) begin
            b_d = (b_q == BW'(BUCKETS - 1)) ? '0 : b_q + 1'b1;
          end
        end
        if (chain_end.vld) begin
          r_d = r_q + 1'b1;
          if (op_q == cqt_pkg::OP_ADD) begin
            hit_d = chain_end.fr_hit;
            hid_d = IW'(chain_end.fr_id);
          end else if (!hit_q && chain_end.hit &&
                       cqt_pkg::time_ge(tv_q, chain_end.hd_time)) begin
            hit_d   = 1'b1;
            hid_d   = IW'(chain_end.hd_id);
            htag_d  = chain_end.hd_tag;
            htime_d = chain_end.hd_time;
            hbkt_d  = BW'(chain_end.bkt);
            hk_d    = r_q;
          end
        end
      end
      cqt_pkg::S_EVAL: begin
        if (op_q == cqt_pkg::OP_ADD) begin
          if (hit_q) begin
            cell_wr.we       = 1'b1;
            cell_wr.id       = cqt_pkg::ID_W'(hid_q);
            cell_wr.deadline = tv_q;
            cell_wr.tag      = hd_q;
            cell_wr.bkt      = cqt_pkg::BKT_W'(b_q);
            cell_wr.order    = ictr_q;
            ictr_d           = ictr_q + 1'b1;
            res_st_d         = cqt_pkg::ST_OK;
            res_id_d         = 6'(hid_q);
          end else begin
            res_st_d = cqt_pkg::ST_FULL;
          end
        end else if (hit_q) begin
          cell_wr.clr = 1'b1;
          cell_wr.id  = cqt_pkg::ID_W'(hid_q);
          cur_d       = hbkt_q;
          mul_a_d     = TW'(hk_q);
          res_st_d    = cqt_pkg::ST_OK;
          res_id_d    = 6'(hid_q);
          res_hdl_d   = htag_q;
          res_to_d    = htime_q;
        end else begin
          mul_a_d  = n_q;
          res_st_d = cqt_pkg::ST_NONE;
        end
      end
      cqt_pkg::S_MUL: prod_d = prod_full;
      cqt_pkg::S_APPLY: begin
        elapsed_d = elapsed_q + prod_q;
        if (!hit_q) cur_d = cur_q + n_q[BW-1:0];
      end
      cqt_pkg::S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d = 1'b1;
          out_st_d  = res_st_q;
          out_id_d  = res_id_q;
          out_hdl_d = res_hdl_q;
          out_to_d  = res_to_q;
        end
      end
      default: ;
    endcase

    // Configuration transfers.
    if (cfg_valid_i) begin
      if (cfg_index_i == cqt_pkg::REG_BUCKET_SPAN) span_d = cfg_data_i;
      if (cfg_index_i == cqt_pkg::REG_START_TIME) elapsed_d = cfg_data_i;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cqt_pkg::S_IDLE;
      span_q    <= TW'(1);
      elapsed_q <= '0;
      ictr_q    <= '0;
      cur_q     <= '0;
      k_q       <= '0;
      r_q       <= '0;
      lim_q     <= '0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      span_q    <= span_d;
      elapsed_q <= elapsed_d;
      ictr_q    <= ictr_d;
      cur_q     <= cur_d;
      k_q       <= k_d;
      r_q       <= r_d;
      lim_q     <= lim_d;
      hit_q     <= hit_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    tv_q      <= tv_d;
    hd_q      <= hd_d;
    id_q      <= id_d;
    b_q       <= b_d;
    n_q       <= n_d;
    mul_a_q   <= mul_a_d;
    prod_q    <= prod_d;
    hk_q      <= hk_d;
    hid_q     <= hid_d;
    htag_q    <= htag_d;
    htime_q   <= htime_d;
    hbkt_q    <= hbkt_d;
    res_st_q  <= res_st_d;
    res_id_q  <= res_id_d;
    res_hdl_q <= res_hdl_d;
    res_to_q  <= res_to_d;
    out_st_q  <= out_st_d;
    out_id_q  <= out_id_d;
    out_hdl_q <= out_hdl_d;
    out_to_q  <= out_to_d;
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = out_st_q;
  assign result_id_o      = out_id_q;
  assign result_handle_o  = out_hdl_q;
  assign result_timeout_o = out_to_q;

  // Waves only leave the chain while a scan collects them.
  `CQT_ASSERT(a_wave_in_scan, clk_i, rst_ni, chain_end.vld |-> state_q == cqt_pkg::S_SCAN)
  // An add only fills a free slot.
  `CQT_ASSERT(a_write_free, clk_i, rst_ni, cell_wr.we |-> !vld_vec[cell_wr.id[IW-1:0]])
  // A remove or an expiry only frees an occupied slot.
  `CQT_ASSERT(a_clear_valid, clk_i, rst_ni, cell_wr.clr |-> vld_vec[cell_wr.id[IW-1:0]])
  // The scan never launches more waves than buckets to visit.
  `CQT_ASSERT(a_launch_bound, clk_i, rst_ni, state_q == cqt_pkg::S_SCAN |-> k_q <= lim_q)
  // An accepted item is decoded in the following cycle.
  `CQT_ASSERT_NEXT(a_accept_decode, clk_i, rst_ni, in_fire, state_q == cqt_pkg::S_DECODE)
endmodule
`default_nettype wire
